### hdl/mslt_pkg.sv
package mslt_pkg;

	// default sizing
	localparam int SLOTS_DEF = 10;
	localparam int CAP_DEF   = 16;

	// longest readout run, in beats
	localparam int MAX_OUT   = 16;

	// widest count that any legal CAP can need
	localparam int CNT_W_MAX = 7;

	// operation codes
	localparam logic [3:0] OP_CREATE   = 4'd0;
	localparam logic [3:0] OP_APPEND   = 4'd1;
	localparam logic [3:0] OP_POP      = 4'd2;
	localparam logic [3:0] OP_DELETE   = 4'd3;
	localparam logic [3:0] OP_READ     = 4'd4;
	localparam logic [3:0] OP_SORTED   = 4'd5;
	localparam logic [3:0] OP_RESIZE   = 4'd6;
	localparam logic [3:0] OP_COUNT    = 4'd7;
	localparam logic [3:0] OP_FREE_ALL = 4'd8;

	// status codes
	localparam logic [3:0] ST_OK           = 4'd0;
	localparam logic [3:0] ST_BAD_SLOT     = 4'd1;
	localparam logic [3:0] ST_BAD_SIZE     = 4'd2;
	localparam logic [3:0] ST_EXISTS       = 4'd3;
	localparam logic [3:0] ST_NO_MEMORY    = 4'd4;
	localparam logic [3:0] ST_NO_SLOT      = 4'd5;
	localparam logic [3:0] ST_FULL         = 4'd6;
	localparam logic [3:0] ST_EMPTY        = 4'd7;
	localparam logic [3:0] ST_NOT_FOUND    = 4'd8;
	localparam logic [3:0] ST_BAD_NEW_SIZE = 4'd9;

	// one result beat from the sequencer to the output register
	typedef struct packed {
		logic [3:0]           status;
		logic [31:0]          data_word;
		logic                 has_data;
		logic                 last;
		logic [CNT_W_MAX-1:0] count;
	} res_t;

endpackage

### hdl/mslt_store.sv
module mslt_store #(
	parameter int DEPTH = 160,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	// one write port, one read port with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/mslt_ctrl.sv
module mslt_ctrl
	import mslt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int CAP   = CAP_DEF,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [3:0]    op,
	input  logic [3:0]    slot,
	input  logic [31:0]   word,
	input  logic [7:0]    amount,
	output logic          res_valid,
	output res_t          res,
	input  logic          res_take,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [31:0]   mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [31:0]   mem_rdata
);

	localparam int CW = $clog2(CAP + 1);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_DECIDE = 10'b0000000010,
		S_DRD    = 10'b0000000100,
		S_DCHK   = 10'b0000001000,
		S_SRD    = 10'b0000010000,
		S_SWR    = 10'b0000100000,
		S_RRD    = 10'b0001000000,
		S_RCHK   = 10'b0010000000,
		S_SSCAN  = 10'b0100000000,
		S_RESP   = 10'b1000000000
	} state_t;

	state_t state_q, ret_q;

	// slot table
	logic [CW-1:0] cap_q   [SLOTS];
	logic [CW-1:0] cnt_q   [SLOTS];
	logic          alloc_q [SLOTS];

	// latched item
	logic [3:0]  op_q;
	logic [3:0]  slot_q;
	logic [31:0] word_q;
	logic [7:0]  amount_q;

	// scan state
	logic [CW-1:0] idx_q, n_q, k_q, sent_q;
	logic          chk_v_s1;
	logic [CW-1:0] chk_idx_s1;
	logic          hp_q, bv_q;
	logic [31:0]   pv_q, bval_q;
	logic [CW-1:0] pi_q, bidx_q;

	res_t res_q;

	// decode of the latched slot
	logic          slot_ok;
	logic [SW-1:0] sidx;
	logic [CW-1:0] cur_cap, cur_cnt;
	logic          cur_alloc;
	logic [AW-1:0] base;
	logic          app_ok;
	logic [CW-1:0] sent_c;

	logic signed [8:0] amt9, cap9, newcap9;

	// sorted scan compare
	logic signed [31:0] sv, spv, sbv;
	logic               elig, better, drain;

	assign slot_ok   = (slot_q >= 4'd1) && ({1'b0, slot_q} <= 5'(SLOTS));
	assign sidx      = SW'(slot_q - 4'd1);
	assign cur_cap   = slot_ok ? cap_q[sidx] : '0;
	assign cur_cnt   = slot_ok ? cnt_q[sidx] : '0;
	assign cur_alloc = slot_ok ? alloc_q[sidx] : 1'b0;
	assign base      = AW'(sidx) * AW'(CAP);
	assign app_ok    = cur_alloc && (cur_cnt < cur_cap);
	assign sent_c    = (int'(cur_cnt) > MAX_OUT) ? CW'(MAX_OUT) : cur_cnt;

	assign amt9    = $signed({amount_q[7], amount_q});
	assign cap9    = $signed(9'(CAP));
	assign newcap9 = $signed(9'(cur_cap)) + amt9;

	assign sv     = $signed(mem_rdata);
	assign spv    = $signed(pv_q);
	assign sbv    = $signed(bval_q);
	assign elig   = !hp_q || (sv > spv) || ((sv == spv) && (chk_idx_s1 > pi_q));
	assign better = !bv_q || (sv < sbv);
	assign drain  = (idx_q == n_q) && !chk_v_s1;

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	// memory addressing
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = base + AW'(idx_q);
		mem_wdata = mem_rdata;
		mem_raddr = base + AW'(idx_q);
		case (state_q)
			S_DECIDE: begin
				mem_we    = slot_ok && (op_q == OP_APPEND) && app_ok;
				mem_waddr = base + AW'(cur_cnt);
				mem_wdata = word_q;
			end
			S_SRD: begin
				mem_raddr = base + AW'(idx_q + CW'(1));
			end
			S_SWR: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer and slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			chk_v_s1 <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				cap_q[i]   <= '0;
				cnt_q[i]   <= '0;
				alloc_q[i] <= 1'b0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= op;
						slot_q   <= slot;
						word_q   <= word;
						amount_q <= amount;
						state_q  <= S_DECIDE;
					end
				end

				S_DECIDE: begin
					res_q.data_word <= '0;
					res_q.has_data  <= 1'b0;
					res_q.last      <= 1'b1;
					res_q.count     <= CNT_W_MAX'(cur_cnt);
					res_q.status    <= ST_OK;
					ret_q           <= S_IDLE;
					state_q         <= S_RESP;
					idx_q           <= '0;
					k_q             <= '0;
					n_q             <= cur_cnt;
					sent_q          <= sent_c;
					hp_q            <= 1'b0;
					bv_q            <= 1'b0;
					chk_v_s1        <= 1'b0;
					if (op_q > OP_FREE_ALL) begin
						state_q <= S_IDLE;
					end else if (op_q == OP_FREE_ALL) begin
						for (int i = 0; i < SLOTS; i++) begin
							cap_q[i]   <= '0;
							cnt_q[i]   <= '0;
							alloc_q[i] <= 1'b0;
						end
						res_q.count <= '0;
					end else if (!slot_ok) begin
						res_q.status <= ST_BAD_SLOT;
						res_q.count  <= '0;
					end else if (op_q == OP_CREATE) begin
						if (amt9 < 9'sd1) begin
							res_q.status <= ST_BAD_SIZE;
						end else if (cur_alloc) begin
							res_q.status <= ST_EXISTS;
						end else if (amt9 > cap9) begin
							res_q.status <= ST_NO_MEMORY;
						end else begin
							alloc_q[sidx] <= 1'b1;
							cap_q[sidx]   <= CW'(amount_q);
							cnt_q[sidx]   <= '0;
							res_q.count   <= '0;
						end
					end else if (!cur_alloc) begin
						res_q.status <= ST_NO_SLOT;
					end else begin
						case (op_q)
							OP_APPEND: begin
								if (app_ok) begin
									cnt_q[sidx] <= cur_cnt + CW'(1);
									res_q.count <= CNT_W_MAX'(cur_cnt + CW'(1));
								end else begin
									res_q.status <= ST_FULL;
								end
							end
							OP_POP: begin
								if (cur_cnt == '0) begin
									res_q.status <= ST_EMPTY;
								end else begin
									cnt_q[sidx] <= cur_cnt - CW'(1);
									res_q.count <= CNT_W_MAX'(cur_cnt - CW'(1));
								end
							end
							OP_DELETE: begin
								if (cur_cnt == '0) begin
									res_q.status <= ST_EMPTY;
								end else begin
									state_q <= S_DRD;
								end
							end
							OP_READ: begin
								if (cur_cnt != '0) begin
									state_q <= S_RRD;
								end
							end
							OP_SORTED: begin
								if (cur_cnt != '0) begin
									state_q <= S_SSCAN;
								end
							end
							OP_RESIZE: begin
								if (newcap9 < 9'sd1) begin
									res_q.status <= ST_BAD_NEW_SIZE;
								end else if (newcap9 > cap9) begin
									res_q.status <= ST_NO_MEMORY;
								end else begin
									cap_q[sidx] <= CW'(newcap9);
									if (cur_cnt > CW'(newcap9)) begin
										cnt_q[sidx] <= CW'(newcap9);
										res_q.count <= CNT_W_MAX'(CW'(newcap9));
									end
								end
							end
							default: begin
								// count query
								if (cur_cnt == '0) begin
									res_q.status <= ST_EMPTY;
								end
							end
						endcase
					end
				end

				// delete: look for the first match
				S_DRD: begin
					state_q <= S_DCHK;
				end

				S_DCHK: begin
					if (mem_rdata == word_q) begin
						state_q <= S_SRD;
					end else if (idx_q + CW'(1) == n_q) begin
						res_q.status <= ST_NOT_FOUND;
						res_q.count  <= CNT_W_MAX'(n_q);
						state_q      <= S_RESP;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_DRD;
					end
				end

				// delete: move later words down one place
				S_SRD: begin
					if (idx_q + CW'(1) < n_q) begin
						state_q <= S_SWR;
					end else begin
						cnt_q[sidx]  <= n_q - CW'(1);
						res_q.status <= ST_OK;
						res_q.count  <= CNT_W_MAX'(n_q - CW'(1));
						state_q      <= S_RESP;
					end
				end

				S_SWR: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_SRD;
				end

				// plain readout, one word per read
				S_RRD: begin
					state_q <= S_RCHK;
				end

				S_RCHK: begin
					res_q.data_word <= mem_rdata;
					res_q.has_data  <= 1'b1;
					res_q.last      <= (idx_q + CW'(1) == sent_q);
					res_q.count     <= CNT_W_MAX'(n_q);
					idx_q           <= idx_q + CW'(1);
					ret_q           <= (idx_q + CW'(1) == sent_q) ? S_IDLE : S_RRD;
					state_q         <= S_RESP;
				end

				// sorted readout: one pass per output finds the next (value, index)
				S_SSCAN: begin
					if (idx_q != n_q) begin
						idx_q <= idx_q + CW'(1);
					end
					chk_v_s1   <= (idx_q != n_q);
					chk_idx_s1 <= idx_q;
					if (chk_v_s1 && elig && better) begin
						bv_q   <= 1'b1;
						bval_q <= mem_rdata;
						bidx_q <= chk_idx_s1;
					end
					if (drain) begin
						res_q.data_word <= bval_q;
						res_q.has_data  <= 1'b1;
						res_q.last      <= (k_q + CW'(1) == sent_q);
						res_q.count     <= CNT_W_MAX'(n_q);
						pv_q            <= bval_q;
						pi_q            <= bidx_q;
						hp_q            <= 1'b1;
						bv_q            <= 1'b0;
						idx_q           <= '0;
						k_q             <= k_q + CW'(1);
						ret_q           <= (k_q + CW'(1) == sent_q) ? S_IDLE : S_SSCAN;
						state_q         <= S_RESP;
					end
				end

				S_RESP: begin
					if (res_take) begin
						state_q <= ret_q;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_DECIDE || state_q == S_SWR))
		else $error("store written outside append or shift");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (int'(res.count) <= CAP))
		else $error("result count above capacity");

	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.has_data) |-> (res.status == ST_OK))
		else $error("data beat with error status");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DECIDE))
		else $error("accepted item not decoded");

endmodule

### hdl/multi_slot_bounded_list_table_core.sv
// Channel | Handshake          | Payload
// in      | in_valid/in_stall  | op, slot, word, amount
// out     | out_valid/out_stall| status, data_word, has_data, last, count
//
// Simple ops pass through the decide state and the result beat into the
// output register; the next item is taken once the sequencer is idle.
// Delete: a read and a check state per word scanned, a read and a write
// state per word moved. Readout: read, check, response state per beat;
// sorted: a scan through the single read port per beat, then a response.
// arst_n clears the slot table and control; the word store is not cleared.
// A waiting result beat stalls the sequencer; a new item is taken once idle.
module multi_slot_bounded_list_table_core
	import mslt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int CAP   = CAP_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [3:0]                op,
	input  logic [3:0]                slot,
	input  logic [31:0]               word,
	input  logic [7:0]                amount,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [3:0]                status,
	output logic [31:0]               data_word,
	output logic                      has_data,
	output logic                      last,
	output logic [$clog2(CAP+1)-1:0]  count
);

	localparam int CW    = $clog2(CAP + 1);
	localparam int DEPTH = SLOTS * CAP;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          res_valid, res_take;
	res_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, mem_rdata;

	logic          out_valid_q;
	res_t          out_q;

	mslt_ctrl #(
		.SLOTS (SLOTS),
		.CAP   (CAP),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.slot      (slot),
		.word      (word),
		.amount    (amount),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	mslt_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: takes a beat whenever it is empty or being drained
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign data_word = out_q.data_word;
	assign has_data  = out_q.has_data;
	assign last      = out_q.last;
	assign count     = out_q.count[CW-1:0];

	a_nodata_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_data) |-> last)
		else $error("beat without data does not close its run");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !res_take)
		else $error("output register overwritten while stalled");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> in_stall)
		else $error("input open while a result is pending");

endmodule

### dv/tb_top.sv
module tb_top;
	import mslt_pkg::*;

	localparam int N_SLOTS = SLOTS_DEF;
	localparam int N_CAP   = CAP_DEF;
	localparam int CW      = $clog2(N_CAP + 1);
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [3:0]    status;
		logic [31:0]   data_word;
		logic          has_data;
		logic          last;
		logic [CW-1:0] count;
	} beat_t;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [3:0]    op;
	logic [3:0]    slot;
	logic [31:0]   word;
	logic [7:0]    amount;
	logic          out_valid;
	logic          out_stall;
	logic [3:0]    status;
	logic [31:0]   data_word;
	logic          has_data;
	logic          last;
	logic [CW-1:0] count;

	multi_slot_bounded_list_table_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .slot(slot), .word(word), .amount(amount),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .data_word(data_word), .has_data(has_data),
		.last(last), .count(count)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// shadow of the slot table
	logic [31:0] tbl_words [N_SLOTS][N_CAP];
	int          tbl_cap   [N_SLOTS];
	int          tbl_cnt   [N_SLOTS];
	bit          tbl_alloc [N_SLOTS];

	beat_t expected_beats[$];
	int    mismatches;
	int    beats_seen;
	int    items_sent;
	int    idle_in_pct;
	int    stall_pct;
	int    quiet_cycles;
	bit    timed_out;

	function automatic beat_t mk(logic [3:0] st, logic [31:0] d, logic h, int c);
		beat_t b;
		b.status = st;
		b.data_word = d;
		b.has_data = h;
		b.last = 1'b1;
		b.count = CW'(c);
		return b;
	endfunction

	task automatic emit_readout(int s, bit sorted);
		logic [31:0] buf_w [N_CAP];
		logic [31:0] t;
		beat_t b;
		int n;
		n = tbl_cnt[s];
		for (int i = 0; i < n; i++)
			buf_w[i] = tbl_words[s][i];
		if (sorted)
			for (int i = 0; i + 1 < n; i++)
				for (int j = 0; j + 1 < n - i; j++)
					if ($signed(buf_w[j]) > $signed(buf_w[j+1])) begin
						t = buf_w[j];
						buf_w[j] = buf_w[j+1];
						buf_w[j+1] = t;
					end
		if (n == 0) begin
			expected_beats.push_back(mk(ST_OK, 0, 0, 0));
			return;
		end
		for (int i = 0; i < n && i < MAX_OUT; i++) begin
			b = mk(ST_OK, buf_w[i], 1, n);
			b.last = (i + 1 == n || i + 1 == MAX_OUT);
			expected_beats.push_back(b);
		end
	endtask

	// table behavior for one accepted item
	task automatic predict_table_op(logic [3:0] o, logic [3:0] sl, logic [31:0] w,
			logic [7:0] a);
		int s, n, amt, nc;
		bit hit;
		amt = $signed(a);
		if (o > OP_FREE_ALL)
			return;
		if (o == OP_FREE_ALL) begin
			for (int i = 0; i < N_SLOTS; i++) begin
				tbl_cap[i] = 0;
				tbl_cnt[i] = 0;
				tbl_alloc[i] = 0;
			end
			expected_beats.push_back(mk(ST_OK, 0, 0, 0));
			return;
		end
		if (sl < 1 || sl > N_SLOTS) begin
			expected_beats.push_back(mk(ST_BAD_SLOT, 0, 0, 0));
			return;
		end
		s = sl - 1;
		if (o == OP_CREATE) begin
			if (amt < 1)
				expected_beats.push_back(mk(ST_BAD_SIZE, 0, 0, tbl_cnt[s]));
			else if (tbl_alloc[s])
				expected_beats.push_back(mk(ST_EXISTS, 0, 0, tbl_cnt[s]));
			else if (amt > N_CAP)
				expected_beats.push_back(mk(ST_NO_MEMORY, 0, 0, tbl_cnt[s]));
			else begin
				tbl_alloc[s] = 1;
				tbl_cap[s] = amt;
				tbl_cnt[s] = 0;
				expected_beats.push_back(mk(ST_OK, 0, 0, 0));
			end
			return;
		end
		if (!tbl_alloc[s]) begin
			expected_beats.push_back(mk(ST_NO_SLOT, 0, 0, tbl_cnt[s]));
			return;
		end
		n = tbl_cnt[s];
		case (o)
			OP_APPEND: begin
				if (n >= tbl_cap[s])
					expected_beats.push_back(mk(ST_FULL, 0, 0, n));
				else begin
					tbl_words[s][n] = w;
					tbl_cnt[s] = n + 1;
					expected_beats.push_back(mk(ST_OK, 0, 0, n + 1));
				end
			end
			OP_POP: begin
				if (n == 0)
					expected_beats.push_back(mk(ST_EMPTY, 0, 0, 0));
				else begin
					tbl_cnt[s] = n - 1;
					expected_beats.push_back(mk(ST_OK, 0, 0, n - 1));
				end
			end
			OP_DELETE: begin
				hit = 0;
				if (n == 0)
					expected_beats.push_back(mk(ST_EMPTY, 0, 0, 0));
				else begin
					for (int i = 0; i < n && !hit; i++)
						if (tbl_words[s][i] == w) begin
							for (int j = i; j + 1 < n; j++)
								tbl_words[s][j] = tbl_words[s][j+1];
							hit = 1;
						end
					if (hit) begin
						tbl_cnt[s] = n - 1;
						expected_beats.push_back(mk(ST_OK, 0, 0, n - 1));
					end else
						expected_beats.push_back(mk(ST_NOT_FOUND, 0, 0, n));
				end
			end
			OP_READ:   emit_readout(s, 0);
			OP_SORTED: emit_readout(s, 1);
			OP_RESIZE: begin
				nc = tbl_cap[s] + amt;
				if (nc < 1)
					expected_beats.push_back(mk(ST_BAD_NEW_SIZE, 0, 0, n));
				else if (nc > N_CAP)
					expected_beats.push_back(mk(ST_NO_MEMORY, 0, 0, n));
				else begin
					tbl_cap[s] = nc;
					if (n > nc)
						tbl_cnt[s] = nc;
					expected_beats.push_back(mk(ST_OK, 0, 0, tbl_cnt[s]));
				end
			end
			default:
				expected_beats.push_back(mk(n == 0 ? ST_EMPTY : ST_OK, 0, 0, n));
		endcase
	endtask

	// send one beat and update the prediction on accept; valid drops only
	// on an idle cycle or when the sender waits for the results
	task automatic send_item(logic [3:0] o, logic [3:0] sl, logic [31:0] w,
			logic [7:0] a);
		while (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		slot <= sl;
		word <= w;
		amount <= a;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_table_op(o, sl, w, a);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	// output side: random stall, check each accepted beat
	always @(posedge clk) begin
		beat_t exp_b;
		beat_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{status, data_word, has_data, last, count};
				beats_seen++;
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: %p", got);
				end else begin
					exp_b = expected_beats.pop_front();
					if (got !== exp_b) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", exp_b, got);
					end
				end
			end
			out_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(7) - 3;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_item(OP_READ, 4'd1, 0, 0);
		send_item(OP_CREATE, 4'd0, 0, 8'd4);
		send_item(OP_CREATE, 4'd15, 0, 8'd4);
		send_item(OP_CREATE, 4'd1, 0, 8'd0);
		send_item(OP_CREATE, 4'd1, 0, 8'h80);
		send_item(OP_CREATE, 4'd1, 0, 8'd17);
		send_item(OP_CREATE, 4'd1, 0, 8'd3);
		send_item(OP_CREATE, 4'd1, 0, 8'd64);
		send_item(OP_COUNT, 4'd1, 0, 0);
		send_item(OP_READ, 4'd1, 0, 0);
		send_item(OP_POP, 4'd1, 0, 0);
		send_item(OP_DELETE, 4'd1, 0, 0);
		send_item(OP_APPEND, 4'd1, 32'h7fff_ffff, 0);
		send_item(OP_APPEND, 4'd1, 32'h8000_0000, 0);
		send_item(OP_APPEND, 4'd1, 32'h0000_0005, 0);
		send_item(OP_APPEND, 4'd1, 32'hffff_ffff, 0);
		send_item(OP_SORTED, 4'd1, 0, 0);
		send_item(OP_DELETE, 4'd1, 32'h1234, 0);
		send_item(OP_DELETE, 4'd1, 32'h8000_0000, 0);
		send_item(OP_RESIZE, 4'd1, 0, 8'd14);
		send_item(OP_RESIZE, 4'd1, 0, 8'd13);
		send_item(OP_RESIZE, 4'd1, 0, 8'hc0);
		send_item(OP_RESIZE, 4'd1, 0, 8'hff);
		send_item(OP_READ, 4'd1, 0, 0);
		send_item(4'd15, 4'd1, 0, 0);
		send_item(OP_FREE_ALL, 4'd9, 0, 0);
		wait_drained();
	endtask

	// mostly legal traffic on few slots, with noise and full-size readouts
	task automatic test_random(int items);
		logic [3:0] o;
		logic [3:0] sl;
		int r;
		for (int k = 0; k < items; k++) begin
			r = $urandom_range(99);
			sl = 4'($urandom_range(1, 4));
			if (r < 30)       o = OP_APPEND;
			else if (r < 40)  o = OP_CREATE;
			else if (r < 48)  o = OP_DELETE;
			else if (r < 55)  o = OP_POP;
			else if (r < 62)  o = OP_READ;
			else if (r < 69)  o = OP_SORTED;
			else if (r < 77)  o = OP_RESIZE;
			else if (r < 83)  o = OP_COUNT;
			else if (r < 85)  o = OP_FREE_ALL;
			else begin
				o = 4'($urandom_range(15));
				sl = 4'($urandom);
			end
			if (o == OP_DELETE && $urandom_range(1) && sl >= 1 && sl <= N_SLOTS
					&& tbl_cnt[sl-1] > 0)
				send_item(o, sl, tbl_words[sl-1][$urandom_range(tbl_cnt[sl-1]-1)],
					8'($urandom));
			else if (o == OP_CREATE && $urandom_range(3) == 0)
				send_item(o, sl, pick_word(), N_CAP);
			else if (o == OP_CREATE || o == OP_RESIZE)
				send_item(o, sl, pick_word(), 8'($signed($urandom_range(40)) - 20));
			else
				send_item(o, sl, pick_word(), 8'($urandom));
		end
		wait_drained();
	endtask

	task automatic test_pause_drain();
		idle_in_pct = 0;
		send_item(OP_CREATE, 4'd10, 0, 8'd16);
		for (int i = 0; i < 17; i++)
			send_item(OP_APPEND, 4'd10, $urandom, 0);
		send_item(OP_SORTED, 4'd10, 0, 0);
		wait_drained();
		send_item(OP_READ, 4'd10, 0, 0);
		send_item(OP_FREE_ALL, 4'd0, 0, 0);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = '0;
		slot = '0;
		word = '0;
		amount = '0;
		out_stall = 1'b0;
		mismatches = 0;
		beats_seen = 0;
		items_sent = 0;
		idle_in_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		timed_out = 0;
		for (int i = 0; i < N_SLOTS; i++) begin
			tbl_cap[i] = 0;
			tbl_cnt[i] = 0;
			tbl_alloc[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		idle_in_pct = 0;  stall_pct = 0;  test_random(90);
		idle_in_pct = 59; stall_pct = 0;  test_random(80);
		test_pause_drain();
		idle_in_pct = 0;  stall_pct = 59; test_random(80);
		idle_in_pct = 33; stall_pct = 33; test_random(90);
		stall_pct = 0;
		wait_drained();
		repeat (200) @(posedge clk);

		$display("Ran %0d items, %0d result beats checked, all ops and idle mixes.",
			items_sent, beats_seen);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
